// ===== design/ffpa_pkg.sv =====
// shared constants and types for the first fit pool allocator
package ffpa_pkg;
    localparam int PoolBytes   = 1024;
    localparam int HeaderBytes = 2;
    localparam int AW          = $clog2(PoolBytes);
    localparam int SW          = AW + 1;
    localparam int HW          = SW + 1;
    localparam int QDEPTH      = 2;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSIZE = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_FAIL  = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind         kind;
        logic [SW-1:0] req;
        logic [AW-1:0] target;
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_FRD, S_FWAIT, S_FCHK,
        S_MRD, S_MWAIT, S_MCHK, S_MNRD, S_MNWAIT, S_MNCHK, S_OUT
    } t_state;
endpackage

// ===== design/ffpa_front.sv =====
// request decode and command queue
module ffpa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_user,
    input  logic [19:0]   i_data,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output ffpa_pkg::t_cmd o_cmd
);
    import ffpa_pkg::*;

    t_cmd r_q [QDEPTH];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cmd w_cmd;
    logic [9:0] w_size, w_addr;
    logic w_push, w_pop;

    assign w_size = i_data[9:0];
    assign w_addr = i_data[19:10];

    always_comb begin
        w_cmd.req    = {1'b0, w_size};
        w_cmd.target = '0;
        if (i_user == FN_ALLOC) begin
            if (w_size == '0 || SW'(w_size) > SW'(PoolBytes - HeaderBytes))
                w_cmd.kind = K_FAIL;
            else
                w_cmd.kind = K_ALLOC;
        end else begin
            w_cmd.target = AW'(w_addr - 10'(HeaderBytes));
            if (w_addr < 10'(HeaderBytes)) w_cmd.kind = K_NOP;
            else w_cmd.kind = K_FREE;
        end
    end

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

// ===== design/ffpa_back.sv =====
// header store walker: allocate, free and merge
module ffpa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  ffpa_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_status,
    output logic [9:0]     o_paddr
);
    import ffpa_pkg::*;

    localparam logic [SW-1:0] PoolSw = SW'(PoolBytes);
    localparam logic [SW-1:0] HdrSw  = SW'(HeaderBytes);

    logic [HW-1:0] r_mem [PoolBytes];
    logic [HW-1:0] r_rd;
    t_state r_st, n_st;
    t_cmd   r_cmd, n_cmd;
    logic [SW-1:0] r_cur, n_cur, r_nxt, n_nxt, r_csz, n_csz;
    logic   r_cused, n_cused;
    logic [1:0] r_status, n_status;
    logic [9:0] r_paddr, n_paddr;
    logic [AW-1:0] w_raddr;
    logic   w_we;
    logic [AW-1:0] w_waddr;
    logic [HW-1:0] w_wdata;
    logic [SW-1:0] w_rsz, w_spare, w_step, w_rest;
    logic   w_rused;

    assign w_rsz   = r_rd[SW-1:0];
    assign w_rused = r_rd[HW-1];
    assign w_step  = r_cur + HdrSw + w_rsz;
    assign w_spare = w_rsz - r_cmd.req;
    assign w_rest  = r_cur + HdrSw + r_cmd.req;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLEAR: n_st = (r_cur == PoolSw - 1'b1) ? S_IDLE : S_CLEAR;
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        K_ALLOC: n_st = S_ARD;
                        K_FREE:  n_st = S_FRD;
                        default: n_st = S_OUT;
                    endcase
                end
            end
            S_ARD:  n_st = S_AWAIT;
            S_AWAIT: n_st = S_ACHK;
            S_ACHK: begin
                if (!w_rused && w_rsz >= r_cmd.req) n_st = S_OUT;
                else if (w_step >= PoolSw) n_st = S_OUT;
                else n_st = S_ARD;
            end
            S_FRD:  n_st = S_FWAIT;
            S_FWAIT: n_st = S_FCHK;
            S_FCHK: begin
                if (r_cur == SW'(r_cmd.target)) n_st = S_MRD;
                else if (r_cur > SW'(r_cmd.target) || w_step >= PoolSw) n_st = S_OUT;
                else n_st = S_FRD;
            end
            S_MRD:  n_st = S_MWAIT;
            S_MWAIT: n_st = S_MCHK;
            S_MCHK: n_st = (w_step >= PoolSw) ? S_OUT : S_MNRD;
            S_MNRD: n_st = S_MNWAIT;
            S_MNWAIT: n_st = S_MNCHK;
            S_MNCHK: n_st = S_MRD;
            S_OUT:  n_st = i_ready ? S_IDLE : S_OUT;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd; n_cur = r_cur; n_nxt = r_nxt; n_csz = r_csz;
        n_cused = r_cused; n_status = r_status; n_paddr = r_paddr;
        w_raddr = r_cur[AW-1:0];
        w_we = 1'b0; w_waddr = r_cur[AW-1:0]; w_wdata = '0;
        case (r_st)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_cur == '0) w_wdata = HW'(PoolBytes - HeaderBytes);
                n_cur = (r_cur == PoolSw - 1'b1) ? '0 : r_cur + 1'b1;
            end
            S_IDLE: begin
                n_cmd = i_cmd; n_cur = '0; n_status = ST_OK; n_paddr = '0;
                if (i_cmd.kind == K_FAIL) n_status = ST_BADSIZE;
            end
            S_ACHK: begin
                if (!w_rused && w_rsz >= r_cmd.req) begin
                    w_we = 1'b1;
                    n_paddr = 10'(r_cur + HdrSw);
                    if (w_spare >= HdrSw) begin
                        w_wdata = {1'b1, r_cmd.req};
                        n_nxt = w_rest; n_csz = w_spare - HdrSw;
                        n_cused = 1'b1;
                    end else begin
                        w_wdata = {1'b1, w_rsz};
                    end
                end else if (w_step >= PoolSw) begin
                    n_status = ST_NOSPACE;
                end else begin
                    n_cur = w_step;
                end
            end
            S_FCHK: begin
                if (r_cur == SW'(r_cmd.target)) begin
                    w_we = 1'b1; w_wdata = {1'b0, w_rsz}; n_cur = '0;
                end else n_cur = w_step;
            end
            S_MCHK: begin
                n_csz = w_rsz; n_cused = w_rused; n_nxt = w_step;
            end
            S_MNRD, S_MNWAIT: w_raddr = r_nxt[AW-1:0];
            S_MNCHK: begin
                if (!r_cused && !w_rused) begin
                    w_we = 1'b1; w_wdata = {1'b0, SW'(r_csz + w_rsz + HdrSw)};
                end else n_cur = r_nxt;
            end
            default: ;
        endcase
    end

    // second write for split remainder and merged-away header
    logic r_w2, n_w2;
    logic [AW-1:0] r_w2a;
    logic [HW-1:0] r_w2d;
    always_comb begin
        n_w2 = 1'b0;
        if (r_st == S_ACHK && !w_rused && w_rsz >= r_cmd.req && w_spare >= HdrSw
            && w_rest < PoolSw) n_w2 = 1'b1;
        if (r_st == S_MNCHK && !r_cused && !w_rused) n_w2 = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR; r_cur <= '0; r_w2 <= 1'b0;
        end else begin
            r_st <= n_st; r_cur <= n_cur; r_w2 <= n_w2;
        end
        r_cmd <= n_cmd; r_nxt <= n_nxt; r_csz <= n_csz; r_cused <= n_cused;
        r_status <= n_status; r_paddr <= n_paddr;
        if (r_st == S_ACHK) begin
            r_w2a <= w_rest[AW-1:0]; r_w2d <= {1'b0, w_spare - HdrSw};
        end else begin
            r_w2a <= r_nxt[AW-1:0]; r_w2d <= '0;
        end
        if (w_we) r_mem[w_waddr] <= w_wdata;
        else if (r_w2) r_mem[r_w2a] <= r_w2d;
        r_rd <= r_mem[w_raddr];
    end

    assign o_cmd_ready = (r_st == S_IDLE);
    assign o_valid     = (r_st == S_OUT);
    assign o_status    = r_status;
    assign o_paddr     = r_paddr;
endmodule

// ===== design/first_fit_pool_allocator.sv =====
// top level of the first fit pool allocator
// requests enter as s_axis beats: tuser selects allocate (0) or free (1),
// tdata carries alloc_size and block_addr.
// each request gives one m_axis beat: status (0 ok, 1 bad size, 2 no space)
// and the payload offset of the allocated block.
// a two-entry command queue decodes and checks sizes ahead of the walker.
// the walker reads block headers one at a time, each through read, wait and
// check states, from a 1024-entry header memory with a registered read port;
// allocate and free walk the chain from offset 0. a rejected request or a
// free below the first payload skips the walk and goes straight to the result.
// a free that hits a block then sweeps the whole chain merging free runs,
// reading the current and the next header at each step.
// one request runs at a time; the next starts the cycle after the result beat
// is taken.
// after reset the header memory is cleared first; requests queue (up to two)
// but are not run until the sweep is done.
// when the receiver stalls the result holds on m_axis and the walker waits;
// the queue keeps taking requests until full.
module first_fit_pool_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,  // func
    input  logic [23:0] s_axis_tdata,  // alloc_size, block_addr, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // status, payload_addr, zero pad
);
    import ffpa_pkg::*;

    logic w_cv, w_cr;
    t_cmd w_cmd;
    logic [1:0] w_status;
    logic [9:0] w_paddr;

    ffpa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_user(s_axis_tuser), .i_data(s_axis_tdata[19:0]),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    ffpa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_paddr(w_paddr)
    );

    assign m_axis_tdata = {4'b0, w_paddr, w_status};
endmodule

// ===== tb/tb_first_fit_pool_allocator.sv =====
// self-checking testbench for the first fit pool allocator
`timescale 1ns / 1ps

module tb_first_fit_pool_allocator;
    import ffpa_pkg::*;

    localparam int StallCycles = 400;
    localparam int WatchLimit  = 20000;
    localparam int RandItems   = 1750;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] paddr;
    } t_outcome;

    typedef struct {
        logic          fn;
        logic [9:0]    size;
        logic [9:0]    addr;
        logic          has_fixed;
        t_outcome      fixed;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic        s_axis_tuser;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    first_fit_pool_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state: one header per byte offset
    logic [15:0] hdr_mem [PoolBytes];
    t_outcome    pending_outcomes [$];
    int unsigned live_addrs [$];
    int          fail_count;
    int          idle_cycles;
    bit          rx_hold;
    bit          stim_done;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic pool_reset();
        for (int k = 0; k < PoolBytes; k++) hdr_mem[k] = '0;
        hdr_mem[0] = 16'(PoolBytes - HeaderBytes);
    endtask

    function automatic int unsigned blk_len(int unsigned off);
        return 32'(hdr_mem[off][14:0]);
    endfunction

    task automatic merge_runs();
        int unsigned cur;
        int unsigned nxt;
        cur = 0;
        while (cur < PoolBytes) begin
            nxt = cur + HeaderBytes + blk_len(cur);
            if (nxt >= PoolBytes) return;
            if (!hdr_mem[cur][15] && !hdr_mem[nxt][15]) begin
                hdr_mem[cur] = 16'((blk_len(cur) + blk_len(nxt) + HeaderBytes) & 16'h7fff);
                hdr_mem[nxt] = '0;
            end else begin
                cur = nxt;
            end
        end
    endtask

    // runs one request on the pool image and returns its result beat
    task automatic pool_apply(input logic fn, input int unsigned size,
                              input int unsigned addr, output t_outcome res);
        int unsigned cur;
        int unsigned spare;
        int unsigned target;
        bit found;
        res = '{ST_OK, '0};
        cur = 0;
        found = 0;
        if (fn == FN_ALLOC) begin
            if (size == 0 || size > PoolBytes - HeaderBytes) begin
                res.status = ST_BADSIZE;
            end else begin
                while (cur < PoolBytes) begin
                    if (!hdr_mem[cur][15] && blk_len(cur) >= size) begin
                        found = 1;
                        break;
                    end
                    cur = cur + HeaderBytes + blk_len(cur);
                end
                if (!found) begin
                    res.status = ST_NOSPACE;
                end else begin
                    spare = blk_len(cur) - size;
                    if (spare >= HeaderBytes) begin
                        hdr_mem[cur] = 16'(size) | 16'h8000;
                        if (cur + HeaderBytes + size < PoolBytes)
                            hdr_mem[cur + HeaderBytes + size] = 16'(spare - HeaderBytes);
                    end else begin
                        hdr_mem[cur][15] = 1'b1;
                    end
                    res.paddr = AW'(cur + HeaderBytes);
                    live_addrs.push_back(cur + HeaderBytes);
                end
            end
        end else if (addr >= HeaderBytes) begin
            target = addr - HeaderBytes;
            while (cur < PoolBytes && cur < target) cur = cur + HeaderBytes + blk_len(cur);
            if (cur == target && cur < PoolBytes) begin
                hdr_mem[cur][15] = 1'b0;
                merge_runs();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // send one request beat after a random gap
    task automatic send_request(input logic fn, input int unsigned size,
                                input int unsigned addr, input bit has_fixed,
                                input t_outcome fixed);
        t_outcome res;
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {4'b0000, 10'(addr), 10'(size)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pool_apply(fn, size, addr, res);
        if (has_fixed && res != fixed)
            report_mismatch("directed row", int'(res), int'(fixed));
        pending_outcomes.push_back(res);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (StallCycles) @(posedge i_clk);
                rx_hold = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected beat", int'(m_axis_tdata), -1);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch("status", m_axis_tdata[1:0], want.status);
                if (m_axis_tdata[11:2] !== want.paddr)
                    report_mismatch("payload_addr", m_axis_tdata[11:2], want.paddr);
                if (m_axis_tdata[15:12] !== 4'b0)
                    report_mismatch("pad", m_axis_tdata[15:12], 0);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || rx_hold)
            idle_cycles <= 0;
        else if (!stim_done || pending_outcomes.size() > 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_outcome none;
        int unsigned pick;
        int unsigned sz;
        int unsigned idx;
        int drain;
        none = '{ST_OK, '0};
        fail_count = 0;
        rx_hold = 0;
        stim_done = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        pool_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{FN_ALLOC, 10'd0, 10'd0, 1, '{ST_BADSIZE, 10'd0}});
        rows.push_back('{FN_ALLOC, 10'd1023, 10'd0, 1, '{ST_BADSIZE, 10'd0}});
        rows.push_back('{FN_ALLOC, 10'd1023, 10'd1023, 1, '{ST_BADSIZE, 10'd0}});
        rows.push_back('{FN_FREE, 10'd0, 10'd2, 1, none});
        rows.push_back('{FN_ALLOC, 10'd1022, 10'd0, 1, '{ST_OK, 10'd2}});
        rows.push_back('{FN_ALLOC, 10'd1, 10'd0, 1, '{ST_NOSPACE, 10'd0}});
        rows.push_back('{FN_FREE, 10'd1023, 10'd2, 1, none});
        rows.push_back('{FN_ALLOC, 10'd1021, 10'd0, 1, '{ST_OK, 10'd2}});
        rows.push_back('{FN_FREE, 10'd0, 10'd2, 1, none});
        // exact remainder leaves a zero-size free block
        rows.push_back('{FN_ALLOC, 10'd1020, 10'd0, 1, '{ST_OK, 10'd2}});
        rows.push_back('{FN_ALLOC, 10'd1, 10'd0, 1, '{ST_NOSPACE, 10'd0}});
        rows.push_back('{FN_FREE, 10'd0, 10'd2, 1, none});
        rows.push_back('{FN_ALLOC, 10'd100, 10'd0, 0, none});
        rows.push_back('{FN_ALLOC, 10'd200, 10'd0, 0, none});
        rows.push_back('{FN_ALLOC, 10'd50, 10'd0, 0, none});
        // addresses that are not block starts are ignored
        rows.push_back('{FN_FREE, 10'd0, 10'd0, 1, none});
        rows.push_back('{FN_FREE, 10'd0, 10'd1, 1, none});
        rows.push_back('{FN_FREE, 10'd0, 10'd50, 1, none});
        rows.push_back('{FN_FREE, 10'd0, 10'd104, 0, none});
        rows.push_back('{FN_FREE, 10'd0, 10'd104, 0, none});
        rows.push_back('{FN_ALLOC, 10'd80, 10'd0, 0, none});
        rows.push_back('{FN_FREE, 10'd0, 10'd2, 0, none});
        rows.push_back('{FN_FREE, 10'd0, 10'd306, 0, none});
        foreach (rows[r])
            send_request(rows[r].fn, rows[r].size, rows[r].addr, rows[r].has_fixed,
                         rows[r].fixed);

        live_addrs.delete();
        for (int n = 0; n < RandItems; n++) begin
            if (n == 300) rx_hold = 1;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // mostly small sizes so the chain stays long
                sz = (pick < 40) ? $urandom_range(1, 40) : $urandom_range(0, 1023);
                send_request(FN_ALLOC, sz, $urandom_range(0, 1023), 0, none);
            end else if (pick < 90 && live_addrs.size() > 0) begin
                idx = $urandom_range(0, live_addrs.size() - 1);
                send_request(FN_FREE, $urandom_range(0, 1023), live_addrs[idx], 0, none);
                live_addrs.delete(idx);
            end else begin
                send_request(FN_FREE, $urandom_range(0, 1023), $urandom_range(0, 1023), 0, none);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;

        drain = 0;
        while (pending_outcomes.size() > 0 && drain < 200000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (3000) @(posedge i_clk);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
